>>> rtl/core/gbtc_pkg.sv
// shared types, register map and constants of the glyph bitmap to texture converter
package gbtc_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned PIX_BITS = 32;

  typedef enum logic [1:0] {
    MODE_GRAY    = 2'd0,
    MODE_MONO    = 2'd1,
    MODE_LCD_RGB = 2'd2,
    MODE_LCD_BGR = 2'd3
  } gbtc_mode_e;

  typedef enum logic [2:0] {
    REG_RENDER_MODE  = 3'd0,
    REG_RGBA_OUTPUT  = 3'd1,
    REG_SOURCE_WIDTH = 3'd2,
    REG_SOURCE_ROWS  = 3'd3,
    REG_ROW_PITCH    = 3'd4
  } gbtc_reg_e;

  // one run of pixels caused by a single source byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] bits;
    logic       mono;
    logic [3:0] count;
    logic       glyph_end;
  } gbtc_run_t;

endpackage

>>> rtl/core/gbtc_pixel_serializer.sv
// run register and output register that give the pixels of one run, one per transfer
module gbtc_pixel_serializer
  import gbtc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                run_valid_i,
  input  gbtc_run_t           run_i,
  output logic                run_ready_o,
  output logic                pix_valid_o,
  input  logic                pix_ready_i,
  output logic [PIX_BITS-1:0] pix_data_o,
  output logic                pix_last_o,
  output logic                pix_glyph_o
);

  logic                run_valid_q, run_valid_d;
  gbtc_run_t           run_q, run_d;
  logic                out_valid_q, out_valid_d;
  logic [PIX_BITS-1:0] out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic                out_glyph_q, out_glyph_d;
  logic                out_load;
  logic                run_last;
  logic [7:0]          pix_alpha;

  assign run_last    = (run_q.count == 4'd1);
  assign out_load    = run_valid_q && (!out_valid_q || pix_ready_i);
  assign run_ready_o = !run_valid_q || (out_load && run_last);
  assign pix_alpha   = run_q.mono ? {8{run_q.bits[7]}} : run_q.alpha;

  always_comb begin
    run_valid_d = run_valid_q;
    run_d       = run_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_glyph_d = out_glyph_q;
    if (pix_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {pix_alpha, run_q.blue, run_q.green, run_q.red};
      out_last_d  = run_last;
      out_glyph_d = run_last && run_q.glyph_end;
      run_d.count = run_q.count - 4'd1;
      run_d.bits  = {run_q.bits[6:0], 1'b0};
      if (run_last) begin
        run_valid_d = 1'b0;
      end
    end
    if (run_valid_i && run_ready_o) begin
      run_valid_d = 1'b1;
      run_d       = run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_valid_q <= run_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q       <= run_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    out_glyph_q <= out_glyph_d;
  end

  assign pix_valid_o = out_valid_q;
  assign pix_data_o  = out_data_q;
  assign pix_last_o  = out_last_q;
  assign pix_glyph_o = out_glyph_q;

endmodule

>>> rtl/core/glyph_bitmap_to_texture_converter_top.sv
// top level of the glyph bitmap to texture converter: registers, row walk, run forming
// path: the first pixel of a byte goes through the run register, then the output register, to m_axis
// throughput: gray and lcd take one byte per cycle while m_axis_tready holds; a mono byte
//   yields 1 to 8 pixels, one per transfer from the single-pixel output register
// reset: rst_ni clears position counters, empties run and output registers and
//   returns the registers to their defaults
module glyph_bitmap_to_texture_converter_top
  import gbtc_pkg::*;
#(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // source_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [PIX_BITS-1:0]      m_axis_tdata,  // red, green, blue, alpha
  output logic                     m_axis_tlast,  // last_of_run
  output logic                     m_axis_tuser   // last_of_glyph
);

  localparam int unsigned W = CoordBits;
  localparam int unsigned RecipShift = W + 1;
  localparam int unsigned RecipMul = ((1 << RecipShift) + 2) / 3;

  // configuration registers
  gbtc_mode_e   mode_q, mode_d;
  logic         rgba_q, rgba_d;
  logic [W-1:0] width_q, width_d;
  logic [W-1:0] rows_q, rows_d;
  logic [W-1:0] pitch_q, pitch_d;
  logic [W-1:0] used_q, used_d;
  logic [W-1:0] span_q, span_d;
  logic         empty_q, empty_d;
  logic         cfg_we;
  gbtc_reg_e    cfg_idx;

  logic [2*W:0] third_prod;
  logic [W-1:0] thirds;
  logic [W+1:0] lcd_used;
  logic [W:0]   mono_sum;
  logic         mode_lcd_d;

  // position state
  logic [W-1:0] row_q, row_d;
  logic [W-1:0] byte_q, byte_d;
  logic [1:0]   phase_q, phase_d;
  logic [7:0]   sub0_q, sub0_d;
  logic [7:0]   sub1_q, sub1_d;

  logic         s_fire;
  logic         in_used;
  logic         last_row;
  logic [W:0]   byte_inc;
  logic [1:0]   phase_eff;
  logic [7:0]   sub0_eff;
  logic [7:0]   sub1_eff;
  logic [W+2:0] mono_rem;
  logic [7:0]   cover_rgb;
  logic         run_valid;
  gbtc_run_t    run;
  logic         run_ready;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = gbtc_reg_e'(paddr[APB_ADDR_BITS-1:2]);

  always_comb begin
    mode_d  = mode_q;
    rgba_d  = rgba_q;
    width_d = width_q;
    rows_d  = rows_q;
    pitch_d = pitch_q;
    if (cfg_we) begin
      case (cfg_idx)
        REG_RENDER_MODE:  mode_d  = gbtc_mode_e'(pwdata[1:0]);
        REG_RGBA_OUTPUT:  rgba_d  = pwdata[0];
        REG_SOURCE_WIDTH: width_d = pwdata[W-1:0];
        REG_SOURCE_ROWS:  rows_d  = pwdata[W-1:0];
        REG_ROW_PITCH:    pitch_d = pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // derived row geometry, kept in step with the registers
  always_comb begin
    third_prod = {{(W+1){1'b0}}, width_d} * {{(W+1){1'b0}}, W'(RecipMul)};
    thirds     = third_prod[RecipShift +: W];
    lcd_used   = {2'b00, thirds} + {1'b0, thirds, 1'b0};
    mono_sum   = {1'b0, width_d} + (W+1)'(7);
    mode_lcd_d = (mode_d == MODE_LCD_RGB) || (mode_d == MODE_LCD_BGR);
    case (mode_d)
      MODE_GRAY: used_d = width_d;
      MODE_MONO: used_d = W'(mono_sum >> 3);
      default:   used_d = lcd_used[W-1:0];
    endcase
    span_d = (pitch_d > used_d) ? pitch_d : used_d;
    if (span_d == '0) begin
      span_d = W'(1);
    end
    empty_d = (width_d == '0) || (rows_d == '0) || (mode_lcd_d && !rgba_d);
  end

  always_comb begin
    case (cfg_idx)
      REG_RENDER_MODE:  prdata = APB_DATA_BITS'(mode_q);
      REG_RGBA_OUTPUT:  prdata = APB_DATA_BITS'(rgba_q);
      REG_SOURCE_WIDTH: prdata = APB_DATA_BITS'(width_q);
      REG_SOURCE_ROWS:  prdata = APB_DATA_BITS'(rows_q);
      REG_ROW_PITCH:    prdata = APB_DATA_BITS'(pitch_q);
      default:          prdata = '0;
    endcase
  end

  // run forming and position update for the byte in transfer
  assign s_axis_tready = run_ready;
  assign s_fire        = s_axis_tvalid && run_ready;

  always_comb begin
    in_used   = !empty_q && (byte_q < used_q);
    last_row  = ({1'b0, row_q} + (W+1)'(1)) >= {1'b0, rows_q};
    byte_inc  = {1'b0, byte_q} + (W+1)'(1);
    phase_eff = (byte_q == '0) ? 2'd0 : phase_q;
    sub0_eff  = (byte_q == '0) ? 8'h00 : sub0_q;
    sub1_eff  = (byte_q == '0) ? 8'h00 : sub1_q;
    mono_rem  = {3'b000, width_q} - {byte_q, 3'b000};
    cover_rgb = rgba_q ? 8'hff : 8'h00;

    phase_d = phase_eff;
    sub0_d  = sub0_eff;
    sub1_d  = sub1_eff;

    run.red       = cover_rgb;
    run.green     = cover_rgb;
    run.blue      = cover_rgb;
    run.alpha     = s_axis_tdata;
    run.bits      = s_axis_tdata;
    run.mono      = 1'b0;
    run.count     = 4'd1;
    run.glyph_end = last_row && (byte_inc == {1'b0, width_q});
    run_valid     = 1'b0;

    if (in_used) begin
      case (mode_q)
        MODE_GRAY: begin
          run_valid = 1'b1;
        end
        MODE_MONO: begin
          run_valid     = 1'b1;
          run.mono      = 1'b1;
          run.count     = (mono_rem > (W+3)'(8)) ? 4'd8 : mono_rem[3:0];
          run.glyph_end = last_row && (mono_rem <= (W+3)'(8));
        end
        default: begin
          run.alpha     = 8'hff;
          run.glyph_end = last_row && (byte_inc == {1'b0, used_q});
          case (phase_eff)
            2'd0: begin
              sub0_d  = s_axis_tdata;
              phase_d = 2'd1;
            end
            2'd1: begin
              sub1_d  = s_axis_tdata;
              phase_d = 2'd2;
            end
            default: begin
              run_valid = 1'b1;
              phase_d   = 2'd0;
              sub0_d    = 8'h00;
              sub1_d    = 8'h00;
              run.green = sub1_eff;
              if (mode_q == MODE_LCD_RGB) begin
                run.red  = sub0_eff;
                run.blue = s_axis_tdata;
              end else begin
                run.red  = s_axis_tdata;
                run.blue = sub0_eff;
              end
            end
          endcase
        end
      endcase
    end

    if (byte_inc >= {1'b0, span_q}) begin
      byte_d = '0;
      row_d  = last_row ? '0 : (row_q + W'(1));
    end else begin
      byte_d = byte_inc[W-1:0];
      row_d  = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_GRAY;
      rgba_q  <= 1'b1;
      width_q <= '0;
      rows_q  <= '0;
      pitch_q <= W'(1);
      used_q  <= '0;
      span_q  <= W'(1);
      empty_q <= 1'b1;
      row_q   <= '0;
      byte_q  <= '0;
      phase_q <= 2'd0;
      sub0_q  <= 8'h00;
      sub1_q  <= 8'h00;
    end else begin
      mode_q  <= mode_d;
      rgba_q  <= rgba_d;
      width_q <= width_d;
      rows_q  <= rows_d;
      pitch_q <= pitch_d;
      used_q  <= used_d;
      span_q  <= span_d;
      empty_q <= empty_d;
      if (s_fire) begin
        row_q   <= row_d;
        byte_q  <= byte_d;
        phase_q <= phase_d;
        sub0_q  <= sub0_d;
        sub1_q  <= sub1_d;
      end
    end
  end

  gbtc_pixel_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (s_fire && run_valid),
    .run_i       (run),
    .run_ready_o (run_ready),
    .pix_valid_o (m_axis_tvalid),
    .pix_ready_i (m_axis_tready),
    .pix_data_o  (m_axis_tdata),
    .pix_last_o  (m_axis_tlast),
    .pix_glyph_o (m_axis_tuser)
  );

endmodule

>>> rtl/core/gbtc_checker.sv
// port-level checks of the glyph bitmap to texture converter, bound to its top level
module gbtc_checker
  import gbtc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic                     pready,
  input logic [APB_ADDR_BITS-1:0] paddr,
  input logic [APB_DATA_BITS-1:0] pwdata,
  input logic [APB_DATA_BITS-1:0] prdata,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [PIX_BITS-1:0]      m_axis_tdata,
  input logic                     m_axis_tlast,
  input logic                     m_axis_tuser
);

  logic cfg_we;
  logic rgba_q;

  assign cfg_we = psel && penable && pwrite && pready;

  // shadow of the output format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgba_q <= 1'b1;
    end else if (cfg_we && (paddr[APB_ADDR_BITS-1:2] == REG_RGBA_OUTPUT)) begin
      rgba_q <= pwdata[0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  a_glyph_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("glyph end not on last pixel of a run");

  a_alpha_only_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !rgba_q |-> m_axis_tdata[23:0] == 24'h000000)
    else $error("color channels nonzero in alpha-only output");

  a_mode_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we && (paddr[APB_ADDR_BITS-1:2] == REG_RENDER_MODE))
      && (paddr[APB_ADDR_BITS-1:2] == REG_RENDER_MODE)
      |-> prdata == {{(APB_DATA_BITS-2){1'b0}}, $past(pwdata[1:0])})
    else $error("render mode readback mismatch");

endmodule

bind glyph_bitmap_to_texture_converter_top gbtc_checker u_gbtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pready        (pready),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> bench/glyph_bitmap_to_texture_converter_top_test.sv
// self-checking testbench of the glyph bitmap to texture converter: directed and random glyphs
module glyph_bitmap_to_texture_converter_top_test;
  import gbtc_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_last;
    logic       glyph_last;
  } texel_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;  // source_byte
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [PIX_BITS-1:0]      m_axis_tdata;  // red, green, blue, alpha
  logic                     m_axis_tlast;  // last_of_run
  logic                     m_axis_tuser;  // last_of_glyph

  // predictor copy of the registers and of the position state
  gbtc_mode_e  cfg_mode = MODE_GRAY;
  logic        cfg_rgba = 1'b1;
  logic [11:0] cfg_width = '0;
  logic [11:0] cfg_rows = '0;
  logic [11:0] cfg_pitch = 12'd1;
  int unsigned row_idx = 0;
  int unsigned byte_pos = 0;
  int unsigned sub_phase = 0;
  logic [15:0] held_sub = '0;

  texel_t expected_texels[$];
  texel_t oldest_texel;
  int     failures = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;

  glyph_bitmap_to_texture_converter_top dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic int unsigned used_bytes(gbtc_mode_e mode, int unsigned w);
    case (mode)
      MODE_GRAY: return w;
      MODE_MONO: return (w + 7) >> 3;
      default:   return (w / 3) * 3;
    endcase
  endfunction

  function automatic bit is_blank(gbtc_mode_e mode, logic rgba, int unsigned w,
                                  int unsigned rows);
    return (w == 0) || (rows == 0) || (mode[1] && !rgba);
  endfunction

  function automatic texel_t coverage_texel(logic [7:0] a, bit glyph_end);
    texel_t t;
    t.red = cfg_rgba ? 8'hff : 8'h00;
    t.green = t.red;
    t.blue = t.red;
    t.alpha = a;
    t.run_last = 1'b0;
    t.glyph_last = glyph_end;
    return t;
  endfunction

  // pixels caused by one accepted source byte, then the position walk
  task automatic convert_byte(input logic [7:0] value);
    int unsigned w;
    int unsigned used;
    int unsigned span;
    int unsigned pos;
    int unsigned first;
    int unsigned cnt;
    bit          last_row;
    texel_t      px[$];
    texel_t      t;
    w = cfg_width;
    used = used_bytes(cfg_mode, w);
    span = (cfg_pitch > used) ? cfg_pitch : used;
    if (span == 0) span = 1;
    pos = byte_pos;
    last_row = (row_idx + 1) >= cfg_rows;
    if (pos == 0) begin
      sub_phase = 0;
      held_sub = '0;
    end
    if (!is_blank(cfg_mode, cfg_rgba, w, cfg_rows) && pos < used) begin
      case (cfg_mode)
        MODE_GRAY: px.push_back(coverage_texel(value, last_row && (pos + 1 == w)));
        MODE_MONO: begin
          first = pos * 8;
          cnt = w - first;
          if (cnt > 8) cnt = 8;
          for (int k = 0; k < cnt; k++)
            px.push_back(coverage_texel(value[7-k] ? 8'hff : 8'h00,
                                        last_row && (first + k + 1 == w)));
        end
        default: begin
          if (sub_phase == 0) begin
            held_sub = {8'h00, value};
            sub_phase = 1;
          end else if (sub_phase == 1) begin
            held_sub[15:8] = value;
            sub_phase = 2;
          end else begin
            t.alpha = 8'hff;
            t.run_last = 1'b0;
            t.glyph_last = last_row && (pos + 1 == used);
            if (cfg_mode == MODE_LCD_RGB) begin
              {t.red, t.green, t.blue} = {held_sub[7:0], held_sub[15:8], value};
            end else begin
              {t.red, t.green, t.blue} = {value, held_sub[15:8], held_sub[7:0]};
            end
            px.push_back(t);
            sub_phase = 0;
            held_sub = '0;
          end
        end
      endcase
    end
    if (px.size() > 0) px[px.size()-1].run_last = 1'b1;
    foreach (px[i]) expected_texels.push_back(px[i]);
    if (pos + 1 >= span) begin
      byte_pos = 0;
      row_idx = last_row ? 0 : ((row_idx + 1) & 12'hfff);
    end else begin
      byte_pos = (pos + 1) & 12'hfff;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_texels.size() == 0) begin
        $error("pixel transfer with nothing expected: tdata %h", m_axis_tdata);
        failures++;
      end else begin
        oldest_texel = expected_texels.pop_front();
        check_field("red", oldest_texel.red, m_axis_tdata[7:0]);
        check_field("green", oldest_texel.green, m_axis_tdata[15:8]);
        check_field("blue", oldest_texel.blue, m_axis_tdata[23:16]);
        check_field("alpha", oldest_texel.alpha, m_axis_tdata[31:24]);
        check_field("last_of_run", 8'(oldest_texel.run_last), 8'(m_axis_tlast));
        check_field("last_of_glyph", 8'(oldest_texel.glyph_last), 8'(m_axis_tuser));
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    convert_byte(value);
  endtask

  // stop sending, drain all pixels, then idle with no bytes sent
  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_texels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic apb_write(input gbtc_reg_e idx, input logic [APB_DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RENDER_MODE:  cfg_mode = gbtc_mode_e'(value[1:0]);
      REG_RGBA_OUTPUT:  cfg_rgba = value[0];
      REG_SOURCE_WIDTH: cfg_width = value[11:0];
      REG_SOURCE_ROWS:  cfg_rows = value[11:0];
      REG_ROW_PITCH:    cfg_pitch = value[11:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input gbtc_mode_e mode, input logic rgba, input int unsigned w,
                            input int unsigned rows, input int unsigned pitch);
    drain_pixels();
    apb_write(REG_RENDER_MODE, APB_DATA_BITS'(mode));
    apb_write(REG_RGBA_OUTPUT, APB_DATA_BITS'(rgba));
    apb_write(REG_SOURCE_WIDTH, APB_DATA_BITS'(w));
    apb_write(REG_SOURCE_ROWS, APB_DATA_BITS'(rows));
    apb_write(REG_ROW_PITCH, APB_DATA_BITS'(pitch));
  endtask

  task automatic test_gray_alpha();
    set_config(MODE_GRAY, 1'b0, 2, 2, 3);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h5a);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'ha5);
  endtask

  task automatic test_mono_rgba();
    set_config(MODE_MONO, 1'b1, 10, 1, 2);
    send_byte(8'ha5);
    send_byte(8'hc0);
  endtask

  // lcd rgb and bgr; a width not a multiple of three drops the odd subpixel
  task automatic test_lcd_modes();
    set_config(MODE_LCD_RGB, 1'b1, 4, 1, 4);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    set_config(MODE_LCD_BGR, 1'b1, 3, 1, 3);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h81);
  endtask

  task automatic test_no_pixels();
    set_config(MODE_LCD_RGB, 1'b0, 3, 1, 3);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    set_config(MODE_GRAY, 1'b1, 0, 1, 1);
    send_byte(8'hee);
  endtask

  // pitch of zero, row span falls back to the used bytes
  task automatic test_short_pitch();
    set_config(MODE_GRAY, 1'b1, 3, 1, 0);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'hfe);
  endtask

  // rows lowered in mid glyph, the current row then counts as the last one
  task automatic test_rows_shrink();
    set_config(MODE_GRAY, 1'b1, 1, 3, 1);
    send_byte(8'h40);
    send_byte(8'h41);
    set_config(MODE_GRAY, 1'b1, 1, 1, 1);
    send_byte(8'h42);
  endtask

  task automatic test_largest_sizes();
    set_config(MODE_MONO, 1'b0, 4095, 4095, 4095);
    send_byte(8'h96);
    send_byte(8'h69);
  endtask

  task automatic test_random_glyphs(input int quota);
    gbtc_mode_e  mode;
    logic        rgba;
    int unsigned w;
    int unsigned rows;
    int unsigned pitch;
    int unsigned used;
    int unsigned span;
    int unsigned glyph_len;
    int unsigned nbytes;
    int          counted;
    int          rounds;
    counted = 0;
    rounds = 0;
    while (counted < quota && rounds < 400) begin
      rounds++;
      mode = gbtc_mode_e'($urandom_range(3));
      rgba = ($urandom_range(3) != 0);
      case ($urandom_range(19))
        0: w = 0;
        1: w = 4095;
        default: w = (mode == MODE_MONO) ? $urandom_range(1, 40) : $urandom_range(1, 20);
      endcase
      case ($urandom_range(11))
        0: rows = 0;
        1: rows = 4095;
        default: rows = $urandom_range(1, 3);
      endcase
      used = used_bytes(mode, w);
      case ($urandom_range(9))
        0: pitch = $urandom_range(1, 4095);
        1: pitch = 1;
        2: pitch = 4095;
        default: pitch = (used + $urandom_range(0, 3) > 4095) ? 4095 :
                         used + $urandom_range(0, 3);
      endcase
      if (pitch == 0) pitch = 1;
      span = (pitch > used) ? pitch : used;
      if (span == 0) span = 1;
      glyph_len = span * ((rows == 0) ? 1 : rows);
      if (glyph_len > 40 || $urandom_range(5) == 0) begin
        nbytes = $urandom_range(1, (glyph_len + 4 > 40) ? 40 : glyph_len + 4);
      end else begin
        nbytes = glyph_len;
      end
      if (nbytes > quota - counted) nbytes = quota - counted;
      set_config(mode, rgba, w, rows, pitch);
      repeat (nbytes) send_byte(8'($urandom_range(255)));
      counted += nbytes;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct = 19;
    snk_idle_pct = 86;
    test_gray_alpha();
    test_mono_rgba();
    test_lcd_modes();
    test_no_pixels();
    test_short_pitch();
    test_rows_shrink();
    test_largest_sizes();
    test_random_glyphs(95);
    src_idle_pct = 86;
    snk_idle_pct = 19;
    test_random_glyphs(95);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_glyphs(95);
    drain_pixels();
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
